FILE: src/lmfw_pkg.sv
// ----------------------------------------------------------------------------
// lmfw_pkg
// Shared types, codes and helpers for the lattice minimum-flip walker: node
// layout, toroidal wrap arithmetic and the node values after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lmfw_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int COORD_W    = $clog2(MAX_SIDE);
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int NODES      = MAX_SIDE * MAX_SIDE;
  localparam int SIDE_W     = 7;
  localparam int LEVEL_BITS = 16;
  localparam int VISIT_BITS = 16;
  localparam int RESET_SIDE = 50;
  localparam int CENTER     = RESET_SIDE / 2;
  localparam int LEVEL_STEP = 2;
  localparam int MIN_SIDE   = 2;
  localparam int PADDR_W    = 3;
  localparam int APB_W      = 32;
  localparam int COUNT_W    = 32;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIDE_W-1:0]  side_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  typedef struct packed {
    logic                  link_x;
    logic                  link_y;
    logic                  part;
    logic [LEVEL_BITS-1:0] level;
    logic [VISIT_BITS-1:0] visits;
  } node_t;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_MOVE  = 2'd1,
    KIND_SWEEP = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_YP = 2'd1,
    DIR_XN = 2'd2,
    DIR_YN = 2'd3
  } dir_e;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_WALK  = 2'd1,
    STAT_FLIP  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_WALK,
    MODE_SWEEP,
    MODE_LOOK
  } mode_e;

  typedef enum logic [0:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_MV,
    S_MVW,
    S_RS,
    S_RL,
    S_RD,
    S_RR,
    S_RU,
    S_EVAL,
    S_WR,
    S_WU,
    S_WL,
    S_WD,
    S_WS
  } fsm_e;

  function automatic addr_t node_addr(coord_t x, coord_t y);
    return {y, x};
  endfunction

  function automatic coord_t inc_w(coord_t v, side_t n);
    side_t nxt;
    nxt = side_t'(v) + side_t'(1);
    return (nxt >= n) ? '0 : nxt[COORD_W-1:0];
  endfunction

  function automatic coord_t dec_w(coord_t v, side_t n);
    side_t top;
    top = n - side_t'(1);
    return (v == '0) ? top[COORD_W-1:0] : v - coord_t'(1);
  endfunction

  function automatic side_t clamp_side(side_t v);
    side_t r;
    r = v;
    if (v < side_t'(MIN_SIDE)) r = side_t'(MIN_SIDE);
    if (v > side_t'(MAX_SIDE)) r = side_t'(MAX_SIDE);
    return r;
  endfunction

  function automatic node_t init_node(coord_t x, coord_t y);
    node_t n;
    logic  p;
    logic  c;
    p = x[0] ^ y[0];
    c = (x == coord_t'(CENTER)) && (y == coord_t'(CENTER));
    n.link_x = p;
    n.link_y = p;
    n.part   = c;
    n.level  = LEVEL_BITS'(p);
    n.visits = VISIT_BITS'(c);
    return n;
  endfunction

endpackage

FILE: src/lattice_min_flip_walker.sv
// ----------------------------------------------------------------------------
// lattice_min_flip_walker
// Toroidal node grid in one synchronous memory; a walker steps over it and
// local minima flip links, raise their level and, on walks, pull in a particle.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                       payload
//  request   in         start & !busy                   kind_i x_i y_i dir_i
//  result    out        strobe_o, one cycle, no stall   status_o site_x_o
//                                                       site_y_o site_level_o
//                                                       particle_moved_o
//                                                       step_total_o
//  config    in/out     apb, psel & penable & pwrite    cols @0x0, rows @0x4
//
// start or sweep: S_RS to S_RU read site and neighbours, S_EVAL judges it and
// a flip writes S_WR to S_WS before the result; a coordinate outside the grid
// answers in the cycle after the request. move or ignored kind: S_MOD wraps
// the walker after the grid shrank (at most 31 steps), then a move reads its
// link in S_MV and S_MVW; the five reads and five writes share the single port
// pair of the node memory. after reset every node is filled with busy high.
// results cannot be stalled; the next request is taken in the strobe cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lattice_min_flip_walker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmfw_pkg::PADDR_W-1:0]  paddr,
  input  logic [lmfw_pkg::APB_W-1:0]    pwdata,
  output logic [lmfw_pkg::APB_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind_i,
  input  lmfw_pkg::coord_t              x_i,
  input  lmfw_pkg::coord_t              y_i,
  input  logic [1:0]                    dir_i,
  output logic                          strobe_o,
  output logic [1:0]                    status_o,
  output lmfw_pkg::coord_t              site_x_o,
  output lmfw_pkg::coord_t              site_y_o,
  output logic [lmfw_pkg::LEVEL_BITS-1:0] site_level_o,
  output logic                          particle_moved_o,
  output logic [lmfw_pkg::COUNT_W-1:0]  step_total_o
);
  import lmfw_pkg::*;

  fsm_e   state_q, state_d;
  side_t  cols_q, cols_d, rows_q, rows_d;
  coord_t walker_x_q, walker_x_d, walker_y_q, walker_y_d;
  logic   active_q, active_d;
  logic [COUNT_W-1:0] step_q, step_d;
  addr_t  init_q, init_d;
  kind_e  kind_q, kind_d;
  dir_e   dir_q, dir_d;
  mode_e  mode_q, mode_d;
  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  node_t  s_q, s_d, l_q, l_d, d_q, d_d, r_q, r_d, u_q, u_d;
  logic   moved_q, moved_d;
  logic   strobe_q, strobe_d;
  status_e status_q, status_d;
  coord_t osx_q, osx_d, osy_q, osy_d;
  logic [LEVEL_BITS-1:0] level_q, level_d;
  logic   omoved_q, omoved_d;

  node_t  node_mem [NODES];
  node_t  rdata_q;
  addr_t  raddr, waddr;
  logic   we;
  node_t  wdata;

  coord_t left_x, right_x, down_y, up_y;
  coord_t nx, ny;
  logic   is_min, any_part, do_flip, cfg_wr, bad_xy;

  assign left_x  = dec_w(cur_x_q, cols_q);
  assign right_x = inc_w(cur_x_q, cols_q);
  assign down_y  = dec_w(cur_y_q, rows_q);
  assign up_y    = inc_w(cur_y_q, rows_q);

  assign bad_xy = (side_t'(x_i) >= cols_q) || (side_t'(y_i) >= rows_q);

  // configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_COLS: cols_d = clamp_side(pwdata[SIDE_W-1:0]);
        REG_ROWS: rows_d = clamp_side(pwdata[SIDE_W-1:0]);
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_COLS: prdata = APB_W'(cols_q);
      REG_ROWS: prdata = APB_W'(rows_q);
      default:  prdata = '0;
    endcase
  end

  // node memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      node_mem[waddr] <= wdata;
    end
    rdata_q <= node_mem[raddr];
  end

  always_comb begin
    state_d    = state_q;
    walker_x_d = walker_x_q;
    walker_y_d = walker_y_q;
    active_d   = active_q;
    step_d     = step_q;
    init_d     = init_q;
    kind_d     = kind_q;
    dir_d      = dir_q;
    mode_d     = mode_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    s_d        = s_q;
    l_d        = l_q;
    d_d        = d_q;
    r_d        = r_q;
    u_d        = u_q;
    moved_d    = moved_q;
    strobe_d   = 1'b0;
    status_d   = status_q;
    osx_d      = osx_q;
    osy_d      = osy_q;
    level_d    = level_q;
    omoved_d   = omoved_q;
    raddr      = node_addr(cur_x_q, cur_y_q);
    we         = 1'b0;
    waddr      = node_addr(cur_x_q, cur_y_q);
    wdata      = s_q;
    nx         = walker_x_q;
    ny         = walker_y_q;
    is_min     = ~s_q.link_x & ~s_q.link_y & l_q.link_x & d_q.link_y;
    any_part   = l_q.part | r_q.part | d_q.part | rdata_q.part;
    do_flip    = 1'b0;

    case (state_q)
      S_INIT: begin
        we     = 1'b1;
        waddr  = init_q;
        wdata  = init_node(init_q[COORD_W-1:0], init_q[ADDR_W-1:COORD_W]);
        init_d = init_q + addr_t'(1);
        if (&init_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          kind_d = kind_e'(kind_i);
          dir_d  = dir_e'(dir_i);
          case (kind_e'(kind_i))
            KIND_START, KIND_SWEEP: begin
              if (bad_xy) begin
                strobe_d = 1'b1;
                status_d = STAT_RANGE;
                osx_d    = x_i;
                osy_d    = y_i;
                level_d  = '0;
                omoved_d = 1'b0;
              end else begin
                cur_x_d = x_i;
                cur_y_d = y_i;
                state_d = S_RS;
                if (kind_e'(kind_i) == KIND_START) begin
                  walker_x_d = x_i;
                  walker_y_d = y_i;
                  active_d   = 1'b1;
                  mode_d     = MODE_WALK;
                end else begin
                  mode_d = MODE_SWEEP;
                end
              end
            end
            default: state_d = S_MOD;
          endcase
        end
      end
      S_MOD: begin
        if ((side_t'(walker_x_q) >= cols_q) || (side_t'(walker_y_q) >= rows_q)) begin
          if (side_t'(walker_x_q) >= cols_q) walker_x_d = walker_x_q - cols_q[COORD_W-1:0];
          if (side_t'(walker_y_q) >= rows_q) walker_y_d = walker_y_q - rows_q[COORD_W-1:0];
        end else begin
          cur_x_d = walker_x_q;
          cur_y_d = walker_y_q;
          if (kind_q == KIND_MOVE && active_q) begin
            state_d = S_MV;
          end else begin
            mode_d  = MODE_LOOK;
            state_d = S_RS;
          end
        end
      end
      S_MV: begin
        case (dir_q)
          DIR_XN:  raddr = node_addr(dec_w(walker_x_q, cols_q), walker_y_q);
          DIR_YN:  raddr = node_addr(walker_x_q, dec_w(walker_y_q, rows_q));
          default: raddr = node_addr(walker_x_q, walker_y_q);
        endcase
        state_d = S_MVW;
      end
      S_MVW: begin
        case (dir_q)
          DIR_XP:  if (rdata_q.link_x)  nx = inc_w(walker_x_q, cols_q);
          DIR_YP:  if (rdata_q.link_y)  ny = inc_w(walker_y_q, rows_q);
          DIR_XN:  if (!rdata_q.link_x) nx = dec_w(walker_x_q, cols_q);
          default: if (!rdata_q.link_y) ny = dec_w(walker_y_q, rows_q);
        endcase
        walker_x_d = nx;
        walker_y_d = ny;
        cur_x_d    = nx;
        cur_y_d    = ny;
        mode_d     = MODE_WALK;
        state_d    = S_RS;
      end
      S_RS: begin
        raddr   = node_addr(cur_x_q, cur_y_q);
        state_d = S_RL;
      end
      S_RL: begin
        s_d     = rdata_q;
        raddr   = node_addr(left_x, cur_y_q);
        state_d = S_RD;
      end
      S_RD: begin
        l_d     = rdata_q;
        raddr   = node_addr(cur_x_q, down_y);
        state_d = S_RR;
      end
      S_RR: begin
        d_d     = rdata_q;
        raddr   = node_addr(right_x, cur_y_q);
        state_d = S_RU;
      end
      S_RU: begin
        r_d     = rdata_q;
        raddr   = node_addr(cur_x_q, up_y);
        state_d = S_EVAL;
      end
      S_EVAL: begin
        u_d     = rdata_q;
        do_flip = is_min && (mode_q != MODE_LOOK);
        moved_d = do_flip && (mode_q == MODE_WALK) && any_part;
        if (do_flip) begin
          state_d = S_WR;
        end else begin
          strobe_d = 1'b1;
          status_d = (mode_q == MODE_WALK) ? STAT_WALK : STAT_NONE;
          osx_d    = cur_x_q;
          osy_d    = cur_y_q;
          level_d  = s_q.level;
          omoved_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      // right before left and up before down, so aliased neighbors on a
      // two-wide grid end with the left/down update
      S_WR: begin
        we    = 1'b1;
        waddr = node_addr(right_x, cur_y_q);
        wdata = r_q;
        if (moved_q) wdata.part = 1'b0;
        state_d = S_WU;
      end
      S_WU: begin
        we    = 1'b1;
        waddr = node_addr(cur_x_q, up_y);
        wdata = u_q;
        if (moved_q) wdata.part = 1'b0;
        state_d = S_WL;
      end
      S_WL: begin
        we           = 1'b1;
        waddr        = node_addr(left_x, cur_y_q);
        wdata        = l_q;
        wdata.link_x = 1'b0;
        if (moved_q) wdata.part = 1'b0;
        state_d = S_WD;
      end
      S_WD: begin
        we           = 1'b1;
        waddr        = node_addr(cur_x_q, down_y);
        wdata        = d_q;
        wdata.link_y = 1'b0;
        if (moved_q) wdata.part = 1'b0;
        state_d = S_WS;
      end
      S_WS: begin
        we           = 1'b1;
        waddr        = node_addr(cur_x_q, cur_y_q);
        wdata        = s_q;
        wdata.link_x = 1'b1;
        wdata.link_y = 1'b1;
        wdata.part   = s_q.part | moved_q;
        wdata.visits = s_q.visits + VISIT_BITS'(moved_q);
        wdata.level  = s_q.level + LEVEL_BITS'(LEVEL_STEP);
        step_d       = step_q + COUNT_W'(1);
        if (mode_q == MODE_WALK) active_d = 1'b0;
        strobe_d = 1'b1;
        status_d = STAT_FLIP;
        osx_d    = cur_x_q;
        osy_d    = cur_y_q;
        level_d  = s_q.level + LEVEL_BITS'(LEVEL_STEP);
        omoved_d = moved_q;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= side_t'(RESET_SIDE);
      rows_q     <= side_t'(RESET_SIDE);
      walker_x_q <= '0;
      walker_y_q <= '0;
      active_q   <= 1'b0;
      step_q     <= '0;
      init_q     <= '0;
      strobe_q   <= 1'b0;
    end else begin
      cols_q     <= cols_d;
      rows_q     <= rows_d;
      walker_x_q <= walker_x_d;
      walker_y_q <= walker_y_d;
      active_q   <= active_d;
      step_q     <= step_d;
      init_q     <= init_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    dir_q    <= dir_d;
    mode_q   <= mode_d;
    cur_x_q  <= cur_x_d;
    cur_y_q  <= cur_y_d;
    s_q      <= s_d;
    l_q      <= l_d;
    d_q      <= d_d;
    r_q      <= r_d;
    u_q      <= u_d;
    moved_q  <= moved_d;
    status_q <= status_d;
    osx_q    <= osx_d;
    osy_q    <= osy_d;
    level_q  <= level_d;
    omoved_q <= omoved_d;
  end

  assign busy             = (state_q != S_IDLE);
  assign strobe_o         = strobe_q;
  assign status_o         = status_q;
  assign site_x_o         = osx_q;
  assign site_y_o         = osy_q;
  assign site_level_o     = level_q;
  assign particle_moved_o = omoved_q;
  assign step_total_o     = step_q;

endmodule

FILE: tb/tb_lattice_min_flip_walker.sv
// ----------------------------------------------------------------------------
// tb_lattice_min_flip_walker
// Self-checking bench for the toroidal minimum-flip walker. A short table of
// requests hits reset values, range errors, wrap and particle capture, then
// random walks and sweeps run over several grid sizes set through the apb
// port. Each result is compared with its typed row or an in-bench grid model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lattice_min_flip_walker;
  import lmfw_pkg::*;

  localparam int PER_PHASE = 112;
  localparam int NROWS     = 24;

  typedef struct packed {
    status_e               status;
    coord_t                sx;
    coord_t                sy;
    logic [LEVEL_BITS-1:0] level;
    logic                  moved;
    logic [COUNT_W-1:0]    total;
  } site_rsp_t;

  typedef struct packed {
    kind_e     kind;
    coord_t    x;
    coord_t    y;
    dir_e      dir;
    logic      typed;
    site_rsp_t want;
  } script_row_t;

  localparam site_rsp_t NO_RSP = '{STAT_NONE, 6'd0, 6'd0, 16'd0, 1'b0, 32'd0};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_W-1:0]      pwdata;
  logic [APB_W-1:0]      prdata;
  logic                  pready;
  logic                  start;
  logic                  busy;
  logic [1:0]            kind_i;
  coord_t                x_i;
  coord_t                y_i;
  logic [1:0]            dir_i;
  logic                  strobe_o;
  logic [1:0]            status_o;
  coord_t                site_x_o;
  coord_t                site_y_o;
  logic [LEVEL_BITS-1:0] site_level_o;
  logic                  particle_moved_o;
  logic [COUNT_W-1:0]    step_total_o;

  // grid model
  logic                  link_x_m [NODES];
  logic                  link_y_m [NODES];
  logic                  part_m   [NODES];
  logic [LEVEL_BITS-1:0] level_m  [NODES];
  int unsigned           grid_cols;
  int unsigned           grid_rows;
  int unsigned           walk_x;
  int unsigned           walk_y;
  bit                    walking;
  logic [COUNT_W-1:0]    flip_count;
  int unsigned           particle_x;
  int unsigned           particle_y;

  site_rsp_t   pending_sites [$];
  site_rsp_t   oldest_site;
  int unsigned mismatches;
  int unsigned idle_pct;

  logic [31:0] cols_seq [8] = '{32'd0, 32'hFFFF_FF83, 32'd64, 32'd65,
                                32'd5, 32'd2, 32'd30, 32'd50};
  logic [31:0] rows_seq [8] = '{32'd1, 32'd127, 32'd64, 32'd2,
                                32'd7, 32'd64, 32'hAAAA_AA9C, 32'd50};

  script_row_t script [NROWS] = '{
    '{KIND_MOVE,  6'd0,  6'd0,  DIR_XP, 1'b1, '{STAT_NONE,  6'd0,  6'd0,  16'd0, 1'b0, 32'd0}},
    '{KIND_NONE,  6'd63, 6'd63, DIR_YN, 1'b1, '{STAT_NONE,  6'd0,  6'd0,  16'd0, 1'b0, 32'd0}},
    '{KIND_START, 6'd63, 6'd63, DIR_YP, 1'b1, '{STAT_RANGE, 6'd63, 6'd63, 16'd0, 1'b0, 32'd0}},
    '{KIND_SWEEP, 6'd50, 6'd0,  DIR_XN, 1'b1, '{STAT_RANGE, 6'd50, 6'd0,  16'd0, 1'b0, 32'd0}},
    '{KIND_SWEEP, 6'd0,  6'd49, DIR_XP, 1'b1, '{STAT_NONE,  6'd0,  6'd49, 16'd1, 1'b0, 32'd0}},
    '{KIND_START, 6'd1,  6'd0,  DIR_XP, 1'b1, '{STAT_WALK,  6'd1,  6'd0,  16'd1, 1'b0, 32'd0}},
    '{KIND_MOVE,  6'd63, 6'd0,  DIR_YP, 1'b1, '{STAT_FLIP,  6'd1,  6'd1,  16'd2, 1'b0, 32'd1}},
    '{KIND_MOVE,  6'd0,  6'd63, DIR_XN, 1'b1, '{STAT_NONE,  6'd1,  6'd1,  16'd2, 1'b0, 32'd1}},
    '{KIND_START, 6'd0,  6'd0,  DIR_YN, 1'b1, '{STAT_FLIP,  6'd0,  6'd0,  16'd2, 1'b0, 32'd2}},
    '{KIND_SWEEP, 6'd2,  6'd0,  DIR_XP, 1'b0, NO_RSP},
    '{KIND_SWEEP, 6'd2,  6'd0,  DIR_YP, 1'b0, NO_RSP},
    '{KIND_START, 6'd49, 6'd49, DIR_XN, 1'b0, NO_RSP},
    '{KIND_START, 6'd24, 6'd25, DIR_YN, 1'b0, NO_RSP},
    '{KIND_MOVE,  6'd0,  6'd0,  DIR_XP, 1'b0, NO_RSP},
    '{KIND_SWEEP, 6'd24, 6'd26, DIR_XP, 1'b0, NO_RSP},
    '{KIND_SWEEP, 6'd23, 6'd25, DIR_XP, 1'b0, NO_RSP},
    '{KIND_SWEEP, 6'd24, 6'd24, DIR_XP, 1'b0, NO_RSP},
    '{KIND_START, 6'd24, 6'd25, DIR_XP, 1'b0, NO_RSP},
    '{KIND_START, 6'd24, 6'd25, DIR_XP, 1'b0, NO_RSP},
    '{KIND_MOVE,  6'd0,  6'd0,  DIR_XN, 1'b0, NO_RSP},
    '{KIND_MOVE,  6'd0,  6'd0,  DIR_YN, 1'b0, NO_RSP},
    '{KIND_MOVE,  6'd0,  6'd0,  DIR_XP, 1'b0, NO_RSP},
    '{KIND_MOVE,  6'd0,  6'd0,  DIR_YP, 1'b0, NO_RSP},
    '{KIND_NONE,  6'd31, 6'd42, DIR_XN, 1'b0, NO_RSP}
  };

  lattice_min_flip_walker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .x_i              (x_i),
    .y_i              (y_i),
    .dir_i            (dir_i),
    .strobe_o         (strobe_o),
    .status_o         (status_o),
    .site_x_o         (site_x_o),
    .site_y_o         (site_y_o),
    .site_level_o     (site_level_o),
    .particle_moved_o (particle_moved_o),
    .step_total_o     (step_total_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int unsigned node_at(int unsigned x, int unsigned y);
    return y * MAX_SIDE + x;
  endfunction

  function automatic int unsigned wrap_up(int unsigned v, int unsigned n);
    return (v + 1 >= n) ? 0 : v + 1;
  endfunction

  function automatic int unsigned wrap_dn(int unsigned v, int unsigned n);
    return (v == 0) ? n - 1 : v - 1;
  endfunction

  function automatic int unsigned fit_side(logic [SIDE_W-1:0] v);
    int unsigned w;
    w = 32'(v);
    if (w < MIN_SIDE) return MIN_SIDE;
    if (w > MAX_SIDE) return MAX_SIDE;
    return w;
  endfunction

  function automatic bit at_minimum(int unsigned x, int unsigned y);
    int unsigned s;
    s = node_at(x, y);
    return !link_x_m[s] && !link_y_m[s] &&
           link_x_m[node_at(wrap_dn(x, grid_cols), y)] &&
           link_y_m[node_at(x, wrap_dn(y, grid_rows))];
  endfunction

  function automatic bit flip_site(int unsigned x, int unsigned y, bit pull);
    int unsigned s, l, r, d, u;
    bit          moved;
    s = node_at(x, y);
    l = node_at(wrap_dn(x, grid_cols), y);
    r = node_at(wrap_up(x, grid_cols), y);
    d = node_at(x, wrap_dn(y, grid_rows));
    u = node_at(x, wrap_up(y, grid_rows));
    moved = 1'b0;
    if (pull && (part_m[l] || part_m[r] || part_m[d] || part_m[u])) begin
      part_m[l] = 1'b0;
      part_m[r] = 1'b0;
      part_m[d] = 1'b0;
      part_m[u] = 1'b0;
      part_m[s] = 1'b1;
      particle_x = x;
      particle_y = y;
      moved = 1'b1;
    end
    link_x_m[s] = 1'b1;
    link_y_m[s] = 1'b1;
    link_x_m[l] = 1'b0;
    link_y_m[d] = 1'b0;
    level_m[s] = level_m[s] + LEVEL_BITS'(LEVEL_STEP);
    flip_count = flip_count + 1;
    return moved;
  endfunction

  task automatic reset_grid();
    for (int unsigned y = 0; y < MAX_SIDE; y++) begin
      for (int unsigned x = 0; x < MAX_SIDE; x++) begin
        link_x_m[node_at(x, y)] = 1'((x + y) % 2);
        link_y_m[node_at(x, y)] = 1'((x + y) % 2);
        level_m[node_at(x, y)]  = LEVEL_BITS'((x + y) % 2);
        part_m[node_at(x, y)]   = 1'b0;
      end
    end
    grid_cols  = RESET_SIDE;
    grid_rows  = RESET_SIDE;
    particle_x = RESET_SIDE / 2;
    particle_y = RESET_SIDE / 2;
    part_m[node_at(particle_x, particle_y)] = 1'b1;
    walk_x     = 0;
    walk_y     = 0;
    walking    = 1'b0;
    flip_count = '0;
  endtask

  task automatic predict_site(input kind_e k, input coord_t x, input coord_t y,
                              input dir_e d, output site_rsp_t r);
    int unsigned wx, wy, s;
    int unsigned xu, yu;
    bit          moved;
    r = '0;
    r.status = STAT_NONE;
    moved = 1'b0;
    xu = 32'(x);
    yu = 32'(y);
    if (k == KIND_START || k == KIND_SWEEP) begin
      r.sx = x;
      r.sy = y;
      if (xu >= grid_cols || yu >= grid_rows) begin
        r.status = STAT_RANGE;
      end else begin
        if (k == KIND_START) begin
          walk_x   = xu;
          walk_y   = yu;
          walking  = 1'b1;
          r.status = STAT_WALK;
          if (at_minimum(xu, yu)) begin
            moved    = flip_site(xu, yu, 1'b1);
            walking  = 1'b0;
            r.status = STAT_FLIP;
          end
        end else if (at_minimum(xu, yu)) begin
          void'(flip_site(xu, yu, 1'b0));
          r.status = STAT_FLIP;
        end
        r.level = level_m[node_at(xu, yu)];
      end
    end else begin
      walk_x = walk_x % grid_cols;
      walk_y = walk_y % grid_rows;
      if (k == KIND_MOVE && walking) begin
        wx = walk_x;
        wy = walk_y;
        s  = node_at(wx, wy);
        case (d)
          DIR_XP: if (link_x_m[s]) wx = wrap_up(wx, grid_cols);
          DIR_YP: if (link_y_m[s]) wy = wrap_up(wy, grid_rows);
          DIR_XN: begin
            if (!link_x_m[node_at(wrap_dn(wx, grid_cols), wy)]) wx = wrap_dn(wx, grid_cols);
          end
          default: begin
            if (!link_y_m[node_at(wx, wrap_dn(wy, grid_rows))]) wy = wrap_dn(wy, grid_rows);
          end
        endcase
        walk_x   = wx;
        walk_y   = wy;
        r.status = STAT_WALK;
        if (at_minimum(wx, wy)) begin
          moved    = flip_site(wx, wy, 1'b1);
          walking  = 1'b0;
          r.status = STAT_FLIP;
        end
      end
      r.sx    = coord_t'(walk_x);
      r.sy    = coord_t'(walk_y);
      r.level = level_m[node_at(walk_x, walk_y)];
    end
    r.moved = moved;
    r.total = flip_count;
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch, %s", $time, what);
    mismatches++;
  endtask

  // entered and left just after a falling edge
  task automatic send_site(input kind_e k, input coord_t x, input coord_t y,
                           input dir_e d, input bit typed, input site_rsp_t want);
    site_rsp_t pred;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    start  = 1'b1;
    kind_i = k;
    x_i    = x;
    y_i    = y;
    dir_i  = d;
    do @(posedge clk_i); while (busy);
    predict_site(k, x, y, d, pred);
    pending_sites.push_back(typed ? want : pred);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_COLS) grid_cols = fit_side(val[SIDE_W-1:0]);
    else grid_rows = fit_side(val[SIDE_W-1:0]);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain_results();
    start = 1'b0;
    while (pending_sites.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_walks(input int unsigned count);
    kind_e       k;
    coord_t      x, y;
    dir_e        d;
    int unsigned r, done;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      d = dir_e'($urandom_range(0, 3));
      x = coord_t'($urandom_range(0, 63));
      y = coord_t'($urandom_range(0, 63));
      if (r < 10) begin
        k = kind_e'($urandom_range(0, 3));
      end else if ((walking && r < 70) || (!walking && r < 20)) begin
        k = KIND_MOVE;
      end else begin
        k = ($urandom_range(0, 3) == 0) ? KIND_SWEEP : KIND_START;
        // stay near the particle so that it gets pulled around
        if (particle_x < grid_cols && particle_y < grid_rows && $urandom_range(0, 1)) begin
          x = coord_t'((particle_x + grid_cols + $urandom_range(0, 4) - 2) % grid_cols);
          y = coord_t'((particle_y + grid_rows + $urandom_range(0, 4) - 2) % grid_rows);
        end else begin
          x = coord_t'($urandom_range(0, grid_cols - 1));
          y = coord_t'($urandom_range(0, grid_rows - 1));
        end
      end
      send_site(k, x, y, d, 1'b0, NO_RSP);
      if (k != KIND_NONE) done++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      if (pending_sites.size() == 0) begin
        report_mismatch("result with no request pending");
      end else begin
        oldest_site = pending_sites.pop_front();
        if (status_o != oldest_site.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, oldest_site.status));
        if (site_x_o != oldest_site.sx)
          report_mismatch($sformatf("site_x %0d, want %0d", site_x_o, oldest_site.sx));
        if (site_y_o != oldest_site.sy)
          report_mismatch($sformatf("site_y %0d, want %0d", site_y_o, oldest_site.sy));
        if (site_level_o != oldest_site.level)
          report_mismatch($sformatf("level %0d, want %0d", site_level_o, oldest_site.level));
        if (particle_moved_o != oldest_site.moved)
          report_mismatch($sformatf("particle_moved %0d, want %0d",
                                    particle_moved_o, oldest_site.moved));
        if (step_total_o != oldest_site.total)
          report_mismatch($sformatf("step_total %0d, want %0d",
                                    step_total_o, oldest_site.total));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    start      = 1'b0;
    kind_i     = KIND_START;
    x_i        = '0;
    y_i        = '0;
    dir_i      = DIR_XP;
    mismatches = 0;
    idle_pct   = 25;
    reset_grid();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < NROWS; i++) begin
      send_site(script[i].kind, script[i].x, script[i].y, script[i].dir,
                script[i].typed, script[i].want);
    end
    run_walks(PER_PHASE);

    for (int p = 0; p < 8; p++) begin
      // leave a walk at the far corner so a smaller grid has to wrap it
      send_site(KIND_START, coord_t'(grid_cols - 1), coord_t'(grid_rows - 1),
                dir_e'($urandom_range(0, 3)), 1'b0, NO_RSP);
      drain_results();
      write_reg(REG_COLS, cols_seq[p]);
      write_reg(REG_ROWS, rows_seq[p]);
      idle_pct = (p == 7 || p % 3 == 1) ? 0 : 25;
      send_site(KIND_MOVE, coord_t'($urandom_range(0, 63)), coord_t'($urandom_range(0, 63)),
                dir_e'($urandom_range(0, 3)), 1'b0, NO_RSP);
      run_walks(PER_PHASE);
    end

    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: lattice_min_flip_walker.f
src/lmfw_pkg.sv
src/lattice_min_flip_walker.sv
tb/tb_lattice_min_flip_walker.sv
